// File: rtl/aesdm_pkg.sv
// ----------------------------------------------------------------------------
// aesdm_pkg
// Types, constants and byte-level functions for the AES-128 decryption block.
// ----------------------------------------------------------------------------
package aesdm_pkg;

  localparam int KEY_WORDS  = 44;
  localparam int NUM_ROUNDS = KEY_WORDS / 4 - 1;
  localparam int RND_W      = $clog2(NUM_ROUNDS + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef logic [127:0]     blk_t;
  typedef logic [31:0]      word_t;
  typedef logic [RND_W-1:0] rnd_t;
  typedef logic [1:0]       mode_t;

  localparam mode_t MODE_ECB  = 2'd0;
  localparam mode_t MODE_CBC  = 2'd1;
  localparam mode_t MODE_PCBC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_HI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IV_LO  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_RUN
  } seq_state_t;

  localparam logic [0:255][7:0] SBOX = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [0:255][7:0] INV_SBOX = {
    128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
    128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
    128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
    128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
    128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
    128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
    128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
    128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d
  };

  function automatic logic [7:0] rcon(input rnd_t r);
    logic [7:0] v;
    unique case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // SubWord(RotWord(w)) ^ rcon
  function automatic word_t key_t_word(input word_t w, input logic [7:0] rc);
    return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  function automatic word_t inv_mix_word(input word_t w);
    logic [7:0] a [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] x2, x4, x8;
    for (int k = 0; k < 4; k++) begin
      a[k]  = w[31-8*k -: 8];
      x2    = xt(a[k]);
      x4    = xt(x2);
      x8    = xt(x4);
      m9[k] = x8 ^ a[k];
      mb[k] = x8 ^ x2 ^ a[k];
      md[k] = x8 ^ x4 ^ a[k];
      me[k] = x8 ^ x4 ^ x2;
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  // byte (row r, column c) sits at index 4c+r, MSB first
  function automatic blk_t inv_sub_shift(input blk_t s);
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127-8*(4*c+r) -: 8] = INV_SBOX[s[127-8*(4*((c+4-r)%4)+r) -: 8]];
      end
    end
    return o;
  endfunction

endpackage

// File: rtl/aesdm_in_if.sv
// ----------------------------------------------------------------------------
// aesdm_in_if
// Ciphertext channel: valid/ready handshake with one 128-bit block.
// ----------------------------------------------------------------------------
interface aesdm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;

  modport source (output valid, output cipher_high, output cipher_low, input ready);
  modport sink (input valid, input cipher_high, input cipher_low, output ready);
endinterface

// File: rtl/aesdm_out_if.sv
// ----------------------------------------------------------------------------
// aesdm_out_if
// Plaintext channel: valid/ready handshake with one 128-bit block.
// ----------------------------------------------------------------------------
interface aesdm_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;

  modport source (output valid, output plain_high, output plain_low, input ready);
  modport sink (input valid, input plain_high, input plain_low, output ready);
endinterface

// File: rtl/aesdm_keystep.sv
// ----------------------------------------------------------------------------
// aesdm_keystep
// One forward step of the AES-128 key schedule (round key r-1 to r).
// ----------------------------------------------------------------------------
module aesdm_keystep
  import aesdm_pkg::*;
(
  input  blk_t key_i,
  input  rnd_t rnd_i,
  output blk_t key_o
);
  word_t n0, n1, n2, n3;

  always_comb begin
    n0 = key_i[127:96] ^ key_t_word(key_i[31:0], rcon(rnd_i));
    n1 = key_i[95:64] ^ n0;
    n2 = key_i[63:32] ^ n1;
    n3 = key_i[31:0] ^ n2;
    key_o = {n0, n1, n2, n3};
  end
endmodule

// File: rtl/aesdm_round.sv
// ----------------------------------------------------------------------------
// aesdm_round
// Shared inverse round: walks the key schedule back one step and applies
// InvShiftRows, InvSubBytes, AddRoundKey and (except last) InvMixColumns.
// ----------------------------------------------------------------------------
module aesdm_round
  import aesdm_pkg::*;
(
  input  blk_t state_i,
  input  blk_t key_i,     // round key of round rnd_i
  input  rnd_t rnd_i,
  output blk_t state_o,
  output blk_t key_o      // round key of round rnd_i-1
);
  word_t w0, w1, w2, w3;
  blk_t  t;

  always_comb begin
    w3 = key_i[31:0] ^ key_i[63:32];
    w2 = key_i[63:32] ^ key_i[95:64];
    w1 = key_i[95:64] ^ key_i[127:96];
    w0 = key_i[127:96] ^ key_t_word(w3, rcon(rnd_i));
    key_o = {w0, w1, w2, w3};
    t = inv_sub_shift(state_i) ^ key_o;
    if (rnd_i == rnd_t'(1)) begin
      state_o = t;
    end else begin
      state_o = {inv_mix_word(t[127:96]), inv_mix_word(t[95:64]),
                 inv_mix_word(t[63:32]), inv_mix_word(t[31:0])};
    end
  end
endmodule

// File: rtl/aes128_block_decrypt_modes.sv
// ----------------------------------------------------------------------------
// aes128_block_decrypt_modes
// AES-128 block decryption with ECB, CBC and PCBC chaining.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one ciphertext block per transaction, out_ch one plaintext
//   block. cfg_we/cfg_idx/cfg_data write mode (0), key high/low (1, 2) and
//   the chaining vector high/low (3, 4); other indexes are ignored.
//   A key write runs the forward key schedule, one round per cycle, and
//   in_ch.ready is low meanwhile. Only the last round key is kept,
//   and each block walks the schedule backwards as it decrypts.
//   Decryption: initial key add on accept, then 10 rounds of the one shared
//   round unit, with the result registered into the output register and
//   out_ch.valid. One block at a time: the next transaction is taken once
//   the previous block sits in the output register.
//   If the receiver stalls, the finished block waits in the last round until
//   the output register frees up.
//   Reset (synchronous, rst_n low) sets mode ECB, key and vector to zero and
//   then runs the key schedule for the all-zero key.
// ----------------------------------------------------------------------------
module aes128_block_decrypt_modes
  import aesdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  aesdm_in_if.sink              in_ch,
  aesdm_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  seq_state_t state_r, state_nxt;
  rnd_t       cnt_r, cnt_nxt;
  blk_t       blk_r, blk_nxt;
  blk_t       key_r, key_nxt;
  blk_t       k10_r, k10_nxt;
  blk_t       cipher_r, cipher_nxt;
  blk_t       cv_r, cv_nxt;
  mode_t      mode_r, mode_nxt;
  logic [63:0] key_hi_r, key_hi_nxt, key_lo_r, key_lo_nxt;
  logic       out_valid_r, out_valid_nxt;
  blk_t       plain_r, plain_nxt;

  blk_t fwd_key, rnd_state, rnd_key, plain_w;
  logic key_wr, accept, out_free, last_step, finish, chained;

  aesdm_keystep u_keystep (
    .key_i (key_r),
    .rnd_i (cnt_r + rnd_t'(1)),
    .key_o (fwd_key)
  );

  aesdm_round u_round (
    .state_i (blk_r),
    .key_i   (key_r),
    .rnd_i   (cnt_r),
    .state_o (rnd_state),
    .key_o   (rnd_key)
  );

  assign key_wr    = cfg_we && (cfg_idx == CFG_KEY_HI || cfg_idx == CFG_KEY_LO);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign last_step = (state_r == ST_RUN) && (cnt_r == rnd_t'(1));
  assign finish    = last_step && out_free;
  assign accept    = in_ch.valid && in_ch.ready;
  assign chained   = (mode_r == MODE_CBC) || (mode_r == MODE_PCBC);
  assign plain_w   = chained ? (rnd_state ^ cv_r) : rnd_state;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (key_wr) begin
          state_nxt = ST_KEY;
        end else if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_KEY: begin
        if (!key_wr && cnt_r == rnd_t'(NUM_ROUNDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ch.ready   = (state_r == ST_IDLE) && !key_wr;
    cnt_nxt       = cnt_r;
    blk_nxt       = blk_r;
    key_nxt       = key_r;
    k10_nxt       = k10_r;
    cipher_nxt    = cipher_r;
    cv_nxt        = cv_r;
    mode_nxt      = mode_r;
    key_hi_nxt    = key_hi_r;
    key_lo_nxt    = key_lo_r;
    plain_nxt     = plain_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE:   mode_nxt   = cfg_data[1:0];
        CFG_KEY_HI: key_hi_nxt = cfg_data;
        CFG_KEY_LO: key_lo_nxt = cfg_data;
        CFG_IV_HI:  cv_nxt[127:64] = cfg_data;
        CFG_IV_LO:  cv_nxt[63:0]   = cfg_data;
        default: ;
      endcase
    end

    if (key_wr) begin
      key_nxt = {key_hi_nxt, key_lo_nxt};
      cnt_nxt = '0;
    end else if (state_r == ST_KEY) begin
      key_nxt = fwd_key;
      cnt_nxt = cnt_r + rnd_t'(1);
      if (cnt_r == rnd_t'(NUM_ROUNDS - 1)) begin
        k10_nxt = fwd_key;
      end
    end else if (accept) begin
      cipher_nxt = {in_ch.cipher_high, in_ch.cipher_low};
      blk_nxt    = {in_ch.cipher_high, in_ch.cipher_low} ^ k10_r;
      key_nxt    = k10_r;
      cnt_nxt    = rnd_t'(NUM_ROUNDS);
    end else if (state_r == ST_RUN && (!last_step || finish)) begin
      blk_nxt = rnd_state;
      key_nxt = rnd_key;
      cnt_nxt = cnt_r - rnd_t'(1);
      if (finish) begin
        plain_nxt     = plain_w;
        out_valid_nxt = 1'b1;
        if (mode_r == MODE_CBC) begin
          cv_nxt = cipher_r;
        end else if (mode_r == MODE_PCBC) begin
          cv_nxt = cipher_r ^ plain_w;
        end
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.plain_high = plain_r[127:64];
  assign out_ch.plain_low  = plain_r[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_KEY;
      cnt_r       <= '0;
      key_r       <= '0;
      mode_r      <= MODE_ECB;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
      cv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      key_r       <= key_nxt;
      mode_r      <= mode_nxt;
      key_hi_r    <= key_hi_nxt;
      key_lo_r    <= key_lo_nxt;
      cv_r        <= cv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r    <= blk_nxt;
    k10_r    <= k10_nxt;
    cipher_r <= cipher_nxt;
    plain_r  <= plain_nxt;
  end

`ifndef SYNTHESIS
  a_no_accept_in_keysched: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KEY) |-> !in_ch.ready)
    else $error("input taken during key schedule");

  a_accept_starts_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN && cnt_r == rnd_t'(NUM_ROUNDS)))
    else $error("accepted block did not start at the last round key");

  a_result_from_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(last_step))
    else $error("result produced outside the last round");
`endif

endmodule
